/* rtl/sbaa_pkg.sv */
// ----------------------------------------------------------------------------
// sbaa_pkg
// Shared widths, defaults, register codes, controller states and the
// command/status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sbaa_pkg;

  // Field widths
  localparam int CH_W       = 4;
  localparam int VAL_W      = 16;
  localparam int TIME_W     = 32;
  localparam int IDX_W      = 6;
  localparam int AVG_W      = 8;
  localparam int DECIM_W    = 7;
  localparam int INTERVAL_W = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  // Internal widths
  localparam int SUM_W  = 32;
  localparam int GSUM_W = 22;
  localparam int FC_W   = 16;
  localparam int DIV_W  = 24;

  // Limits and defaults
  localparam int DECIM_MAX    = 64;
  localparam int DECIM_RST    = 1;
  localparam int INTERVAL_RST = 1000;
  localparam int OUT_BINS_DEF = 64;
  localparam int NUM_CH_DEF   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIM    = 1'd0,
    CFG_INTERVAL = 1'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REDO_GO,
    S_REDO,
    S_EVAL,
    S_GDIV,
    S_FRAME,
    S_FRD,
    S_FDIV,
    S_FWAIT,
    S_FOUT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic eval;
    logic grp_write;
    logic frame;
    logic redo_start;
    logic redo_load;
    logic fdiv_start;
    logic avg_load;
    logic emit;
    logic use_port_addr;
    logic flush_addr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic decim_wr;
    logic grp_cmpl;
    logic div_done;
    logic do_flush;
    logic run_last;
  } status_t;

endpackage

/* rtl/spectrum_bin_average_accumulator.sv */
// ----------------------------------------------------------------------------
// spectrum_bin_average_accumulator
// Per-channel spectrum bin decimator and averaging accumulator.
// ----------------------------------------------------------------------------
// Input beats are taken one at a time; a beat that closes a bin group also
// waits for the shared one-bit-per-cycle divider (24 bits). A flush emits
// OUT_BINS result beats, each read, divided and then held while output stalls.
// A write to decim_factor stalls input, the write cycle included, while the
// divider rebuilds the group position. Reset (rst_n low, synchronous) starts
// a clearing pass over all NUM_CHANNELS*OUT_BINS bin sums before the first
// input beat.
// ----------------------------------------------------------------------------
module spectrum_bin_average_accumulator #(
  parameter int OUT_BINS     = sbaa_pkg::OUT_BINS_DEF,
  parameter int NUM_CHANNELS = sbaa_pkg::NUM_CH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [sbaa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sbaa_pkg::CFG_W-1:0]        cfg_wdata,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sbaa_pkg::CH_W-1:0]         in_channel,
  input  logic signed [sbaa_pkg::VAL_W-1:0] in_bin_value,
  input  logic [sbaa_pkg::TIME_W-1:0]       in_now,
  input  logic                              in_last_in_frame,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sbaa_pkg::CH_W-1:0]         out_channel,
  output logic [sbaa_pkg::IDX_W-1:0]        out_bin_index,
  output logic signed [sbaa_pkg::AVG_W-1:0] out_average,
  output logic [sbaa_pkg::TIME_W-1:0]       out_stamp,
  output logic                              out_last_of_run
);
  import sbaa_pkg::*;

  cmd_t    cmd;
  status_t st;

  // Controller: sequences clearing, input beats, rebuild and the flush readout
  sbaa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  // Datapath: group sums, bin sum memory, per-channel tables and divider
  sbaa_datapath #(
    .OUT_BINS     (OUT_BINS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_channel       (in_channel),
    .in_bin_value     (in_bin_value),
    .in_now           (in_now),
    .in_last_in_frame (in_last_in_frame),
    .out_channel      (out_channel),
    .out_bin_index    (out_bin_index),
    .out_average      (out_average),
    .out_stamp        (out_stamp),
    .out_last_of_run  (out_last_of_run)
  );

  // Hold input while a result beat is offered
  a_stall_during_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input not stalled during flush");

  // An accepted input beat never produces a result in the next cycle
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result right after input beat");

  // Each taken result beat is followed by a gap for the next bin read
  a_gap_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("back-to-back result beats");

endmodule

/* rtl/sbaa_ram.sv */
// ----------------------------------------------------------------------------
// sbaa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbaa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sbaa_div.sv */
// ----------------------------------------------------------------------------
// sbaa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbaa_div #(
  parameter int DVW = 24,
  parameter int DSW = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient,
  output logic [DSW-1:0] remainder
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DVW-1:0]  quo_r, quo_nxt;
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DSW-1:0]  dvs_r, dvs_nxt;
  logic [DSW:0]    rem_sh;
  logic [DSW+1:0]  diff;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DVW-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge       = ~diff[DSW+1];
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNTW'(DVW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
      quo_nxt = {quo_r[DVW-2:0], ge};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/sbaa_datapath.sv */
// ----------------------------------------------------------------------------
// sbaa_datapath
// Group summing, per-channel tables, bin sum memory, shared divider and the
// result registers.
// ----------------------------------------------------------------------------
module sbaa_datapath #(
  parameter int OUT_BINS     = sbaa_pkg::OUT_BINS_DEF,
  parameter int NUM_CHANNELS = sbaa_pkg::NUM_CH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sbaa_pkg::cmd_t                        cmd,
  output sbaa_pkg::status_t                     st,
  input  logic                                  cfg_we,
  input  logic [sbaa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sbaa_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [sbaa_pkg::CH_W-1:0]             in_channel,
  input  logic signed [sbaa_pkg::VAL_W-1:0]     in_bin_value,
  input  logic [sbaa_pkg::TIME_W-1:0]           in_now,
  input  logic                                  in_last_in_frame,
  output logic [sbaa_pkg::CH_W-1:0]             out_channel,
  output logic [sbaa_pkg::IDX_W-1:0]            out_bin_index,
  output logic signed [sbaa_pkg::AVG_W-1:0]     out_average,
  output logic [sbaa_pkg::TIME_W-1:0]           out_stamp,
  output logic                                  out_last_of_run
);
  import sbaa_pkg::*;

  localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int DEPTH  = NUM_CHANNELS * OUT_BINS;
  localparam int BIN_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OIW    = $clog2(OUT_BINS + 1);
  localparam int JW     = (OUT_BINS > 1) ? $clog2(OUT_BINS) : 1;
  localparam int POSW   = $clog2(DECIM_MAX * OUT_BINS + 1);
  localparam int GRPW   = $clog2(DECIM_MAX);

  // Control registers
  logic [DECIM_W-1:0]      decim_r, decim_nxt;
  logic [INTERVAL_W-1:0]   interval_r, interval_nxt;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;
  logic signed [GSUM_W-1:0] gsum_r, gsum_nxt;
  logic [POSW-1:0]         pos_r, pos_nxt;
  logic [GRPW-1:0]         grp_r, grp_nxt;
  logic [OIW-1:0]          oidx_r, oidx_nxt;
  logic [BIN_AW-1:0]       clr_r, clr_nxt;

  // Payload registers
  logic [CH_W-1:0]          ch_r, ch_nxt;
  logic signed [VAL_W-1:0]  val_r, val_nxt;
  logic [TIME_W-1:0]        now_r, now_nxt;
  logic                     last_r, last_nxt;
  logic [TIME_W-1:0]        ft_r, ft_nxt;
  logic [FC_W-1:0]          fc_r, fc_nxt;
  logic [JW-1:0]            j_r, j_nxt;
  logic                     neg_r, neg_nxt;
  logic [AVG_W-1:0]         avg_r, avg_nxt;

  // Combinational
  logic [DECIM_W-1:0]       d_eff;
  logic [CH_AW-1:0]         ch_idx;
  logic                     in_range;
  logic                     acc;
  logic                     first;
  logic signed [GSUM_W-1:0] gsum_add;
  logic [GSUM_W-1:0]        gabs;
  logic                     grp_end;
  logic [FC_W-1:0]          fc_new;
  logic                     flush;
  logic [SUM_W-1:0]         bin_mag;
  logic [SUM_W:0]           q_ext;
  logic [SUM_W:0]           sum_ext;
  logic [SUM_W-1:0]         sat_sum;

  // Memory and divider wiring
  logic                     bin_we;
  logic [BIN_AW-1:0]        bin_waddr, bin_raddr;
  logic [SUM_W-1:0]         bin_wdata, bin_rd;
  logic                     time_we;
  logic [CH_AW-1:0]         tab_raddr;
  logic [TIME_W-1:0]        time_rd;
  logic                     fc_we;
  logic [CH_AW-1:0]         fc_waddr;
  logic [FC_W-1:0]          fc_wdata, fc_rd;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dvd, div_quo;
  logic [FC_W-1:0]          div_dvs, div_rem;
  logic                     div_done;

  always_comb begin
    if (decim_r == '0) begin
      d_eff = DECIM_W'(1);
    end else if (decim_r > DECIM_W'(DECIM_MAX)) begin
      d_eff = DECIM_W'(DECIM_MAX);
    end else begin
      d_eff = decim_r;
    end
  end

  assign ch_idx   = CH_AW'(ch_r);
  assign in_range = (32'(ch_r) < NUM_CHANNELS);
  assign acc      = in_range && (oidx_r < OIW'(OUT_BINS));
  assign first    = in_range && !valid_r[ch_idx];
  assign gsum_add = gsum_r + GSUM_W'(val_r);
  assign gabs     = gsum_add[GSUM_W-1] ? (~gsum_add + GSUM_W'(1)) : gsum_add;
  assign grp_end  = (DECIM_W'(grp_r) + DECIM_W'(1)) == d_eff;
  assign fc_new   = (fc_rd == {FC_W{1'b1}}) ? fc_rd : fc_rd + FC_W'(1);
  assign flush    = last_r && in_range &&
                    ((now_r - ft_r) > TIME_W'(interval_r));
  assign bin_mag  = bin_rd[SUM_W-1] ? (~bin_rd + SUM_W'(1)) : bin_rd;

  // Saturating add of the signed group quotient into the bin sum
  always_comb begin
    q_ext   = neg_r ? ((SUM_W+1)'(0) - (SUM_W+1)'(div_quo)) : (SUM_W+1)'(div_quo);
    sum_ext = {bin_rd[SUM_W-1], bin_rd} + q_ext;
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sat_sum = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = sum_ext[SUM_W-1:0];
    end
  end

  // Status
  assign st.clr_last = (clr_r == BIN_AW'(DEPTH - 1));
  assign st.decim_wr = cfg_we && (cfg_index == CFG_DECIM);
  assign st.grp_cmpl = acc && grp_end;
  assign st.div_done = div_done;
  assign st.do_flush = flush;
  assign st.run_last = (j_r == JW'(OUT_BINS - 1));

  // Memory addressing
  always_comb begin
    if (cmd.use_port_addr) begin
      bin_raddr = BIN_AW'(int'(CH_AW'(in_channel)) * OUT_BINS + int'(oidx_r));
      tab_raddr = CH_AW'(in_channel);
    end else if (cmd.flush_addr) begin
      bin_raddr = BIN_AW'(int'(ch_idx) * OUT_BINS + int'(j_r));
      tab_raddr = ch_idx;
    end else begin
      bin_raddr = BIN_AW'(int'(ch_idx) * OUT_BINS + int'(oidx_r));
      tab_raddr = ch_idx;
    end

    bin_we    = cmd.clr_step || cmd.grp_write || cmd.emit;
    bin_wdata = cmd.grp_write ? sat_sum : '0;
    if (cmd.clr_step) begin
      bin_waddr = clr_r;
    end else if (cmd.emit) begin
      bin_waddr = BIN_AW'(int'(ch_idx) * OUT_BINS + int'(j_r));
    end else begin
      bin_waddr = BIN_AW'(int'(ch_idx) * OUT_BINS + int'(oidx_r));
    end

    time_we = (cmd.eval && first) || (cmd.frame && flush);

    fc_we    = (cmd.clr_step && (32'(clr_r) < NUM_CHANNELS)) ||
               (cmd.frame && last_r && in_range);
    fc_waddr = cmd.clr_step ? CH_AW'(clr_r) : ch_idx;
    fc_wdata = (cmd.clr_step || flush) ? '0 : fc_new;
  end

  // Divider operand selection
  always_comb begin
    div_start = (cmd.eval && acc && grp_end) || cmd.redo_start || cmd.fdiv_start;
    if (cmd.fdiv_start) begin
      div_dvd = bin_mag[SUM_W-1:SUM_W-DIV_W];
      div_dvs = fc_r;
    end else if (cmd.redo_start) begin
      div_dvd = DIV_W'(pos_r);
      div_dvs = FC_W'(d_eff);
    end else begin
      div_dvd = DIV_W'(gabs);
      div_dvs = FC_W'(d_eff);
    end
  end

  // Next-state of the registers
  always_comb begin
    decim_nxt    = decim_r;
    interval_nxt = interval_r;
    valid_nxt    = valid_r;
    gsum_nxt     = gsum_r;
    pos_nxt      = pos_r;
    grp_nxt      = grp_r;
    oidx_nxt     = oidx_r;
    clr_nxt      = clr_r;
    ch_nxt       = ch_r;
    val_nxt      = val_r;
    now_nxt      = now_r;
    last_nxt     = last_r;
    ft_nxt       = ft_r;
    fc_nxt       = fc_r;
    j_nxt        = j_r;
    neg_nxt      = neg_r;
    avg_nxt      = avg_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_DECIM:    decim_nxt = cfg_wdata[DECIM_W-1:0];
        CFG_INTERVAL: interval_nxt = cfg_wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end

    if (cmd.clr_step) begin
      clr_nxt = clr_r + BIN_AW'(1);
    end

    if (cmd.accept) begin
      ch_nxt   = in_channel;
      val_nxt  = in_bin_value;
      now_nxt  = in_now;
      last_nxt = in_last_in_frame;
    end

    if (cmd.eval) begin
      if (first) begin
        valid_nxt[ch_idx] = 1'b1;
      end
      ft_nxt = first ? now_r : time_rd;
      if (acc) begin
        pos_nxt = pos_r + POSW'(1);
        if (grp_end) begin
          neg_nxt = gsum_add[GSUM_W-1];
        end else begin
          grp_nxt  = grp_r + GRPW'(1);
          gsum_nxt = gsum_add;
        end
      end
    end

    if (cmd.grp_write) begin
      gsum_nxt = '0;
      grp_nxt  = '0;
      oidx_nxt = oidx_r + OIW'(1);
    end

    if (cmd.frame) begin
      if (last_r) begin
        pos_nxt  = '0;
        grp_nxt  = '0;
        oidx_nxt = '0;
        gsum_nxt = '0;
      end
      fc_nxt = fc_new;
      j_nxt  = '0;
    end

    if (cmd.redo_load) begin
      oidx_nxt = (div_quo >= DIV_W'(OUT_BINS)) ? OIW'(OUT_BINS) : OIW'(div_quo);
      grp_nxt  = div_rem[GRPW-1:0];
    end

    if (cmd.fdiv_start) begin
      neg_nxt = bin_rd[SUM_W-1];
    end

    if (cmd.avg_load) begin
      if (!neg_r) begin
        avg_nxt = (div_quo > DIV_W'(127)) ? AVG_W'(127) : div_quo[AVG_W-1:0];
      end else begin
        avg_nxt = (div_quo > DIV_W'(128)) ? {1'b1, {(AVG_W-1){1'b0}}}
                                          : (AVG_W'(0) - div_quo[AVG_W-1:0]);
      end
    end

    if (cmd.emit) begin
      j_nxt = j_r + JW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decim_r    <= DECIM_W'(DECIM_RST);
      interval_r <= INTERVAL_W'(INTERVAL_RST);
      valid_r    <= '0;
      gsum_r     <= '0;
      pos_r      <= '0;
      grp_r      <= '0;
      oidx_r     <= '0;
      clr_r      <= '0;
      j_r        <= '0;
    end else begin
      decim_r    <= decim_nxt;
      interval_r <= interval_nxt;
      valid_r    <= valid_nxt;
      gsum_r     <= gsum_nxt;
      pos_r      <= pos_nxt;
      grp_r      <= grp_nxt;
      oidx_r     <= oidx_nxt;
      clr_r      <= clr_nxt;
      j_r        <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    val_r  <= val_nxt;
    now_r  <= now_nxt;
    last_r <= last_nxt;
    ft_r   <= ft_nxt;
    fc_r   <= fc_nxt;
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
  end

  sbaa_ram #(.WIDTH(SUM_W), .DEPTH(DEPTH)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rd)
  );

  sbaa_ram #(.WIDTH(TIME_W), .DEPTH(NUM_CHANNELS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (ch_idx),
    .wdata (now_r),
    .raddr (tab_raddr),
    .rdata (time_rd)
  );

  sbaa_ram #(.WIDTH(FC_W), .DEPTH(NUM_CHANNELS)) u_fc_ram (
    .clk   (clk),
    .we    (fc_we),
    .waddr (fc_waddr),
    .wdata (fc_wdata),
    .raddr (tab_raddr),
    .rdata (fc_rd)
  );

  sbaa_div #(.DVW(DIV_W), .DSW(FC_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign out_channel     = ch_r;
  assign out_bin_index   = IDX_W'(j_r);
  assign out_average     = avg_r;
  assign out_stamp       = now_r;
  assign out_last_of_run = (j_r == JW'(OUT_BINS - 1));

endmodule

/* rtl/sbaa_ctrl.sv */
// ----------------------------------------------------------------------------
// sbaa_ctrl
// Sequencer: clearing pass, group position rebuild, item evaluation, group
// division, frame end and flush readout.
// ----------------------------------------------------------------------------
module sbaa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_stall,
  input  sbaa_pkg::status_t st,
  output sbaa_pkg::cmd_t    cmd,
  output logic              in_stall,
  output logic              out_valid
);
  import sbaa_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (st.decim_wr) begin
          state_nxt = S_REDO_GO;
        end else if (in_valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_REDO_GO: state_nxt = S_REDO;
      S_REDO:    if (st.div_done) state_nxt = S_IDLE;
      S_EVAL:    state_nxt = st.grp_cmpl ? S_GDIV : S_FRAME;
      S_GDIV:    if (st.div_done) state_nxt = S_FRAME;
      S_FRAME:   state_nxt = st.do_flush ? S_FRD : S_IDLE;
      S_FRD:     state_nxt = S_FDIV;
      S_FDIV:    state_nxt = S_FWAIT;
      S_FWAIT:   if (st.div_done) state_nxt = S_FOUT;
      S_FOUT: begin
        if (!out_stall) begin
          state_nxt = st.run_last ? S_IDLE : S_FRD;
        end
      end
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_CLEAR:   cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.use_port_addr = 1'b1;
        in_stall          = st.decim_wr;
        cmd.accept        = in_valid && !st.decim_wr;
      end
      S_REDO_GO: cmd.redo_start = 1'b1;
      S_REDO:    cmd.redo_load = st.div_done;
      S_EVAL:    cmd.eval = 1'b1;
      S_GDIV:    cmd.grp_write = st.div_done;
      S_FRAME:   cmd.frame = 1'b1;
      S_FRD:     cmd.flush_addr = 1'b1;
      S_FDIV: begin
        cmd.flush_addr = 1'b1;
        cmd.fdiv_start = 1'b1;
      end
      S_FWAIT: begin
        cmd.flush_addr = 1'b1;
        cmd.avg_load   = st.div_done;
      end
      S_FOUT: begin
        cmd.flush_addr = 1'b1;
        out_valid      = 1'b1;
        cmd.emit       = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
